// ===== hw/rtl/mma_pkg.sv =====
`timescale 1ns / 1ps

package mma_pkg;

    localparam int CHANNELS    = 8;
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 12;

    localparam int CH_W    = $clog2(CHANNELS);
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int ADDR_W  = CH_W + PTR_W;

    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;
    localparam logic [6:0] WINDOW_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_PUSH      = 2'd0,
        ACT_CLEAR_CH  = 2'd1,
        ACT_CLEAR_ALL = 2'd2,
        ACT_QUERY     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_EVAL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  channel;
        logic [11:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [11:0] average;
        logic [6:0]  sample_count;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/mma_divider.sv =====
`timescale 1ns / 1ps

module mma_divider import mma_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  dvs_reg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            step_reg <= STEP_W'(SUM_W - 1);
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            rem_reg  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_reg  <= {quo_reg[SUM_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/multichannel_moving_average_top.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake        payload
// s_       in         s_valid/s_ready  in_item_t  {action, channel, sample}
// m_       out        m_valid/m_ready  out_item_t {average, sample_count}
// apb      in         psel/penable     window_length at byte address 0
//
// A transfer on a nonempty channel passes through read, update, eval,
// 18 divider steps plus the divider's done, done and idle before the next
// s_ready. An empty channel skips the divider. s_ready is high only in idle;
// a result still waiting in the output register holds the block in done.
// Reset and every window_length write empty all channels at once.

module multichannel_moving_average_top import mma_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    state_t state_reg, state_next;

    logic [6:0]       wlen_reg;
    in_item_t         item_reg;
    logic [11:0]      res_avg_reg, res_avg_next;
    logic [6:0]       res_cnt_reg, res_cnt_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;

    logic [PTR_W-1:0] wp_reg   [CHANNELS];
    logic [CNT_W-1:0] held_reg [CHANNELS];
    logic [SUM_W-1:0] sum_reg  [CHANNELS];

    logic [SAMPLE_BITS-1:0] sample_mem [CHANNELS * MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic             cfg_we;
    logic             accept;
    logic             clear_all;
    logic             ch_wr;
    logic             mem_we;
    logic             ch_ok;
    logic [CH_W-1:0]  ch_idx;
    logic [CNT_W-1:0] win;
    logic [PTR_W-1:0] ptr_eff;
    logic [CNT_W-1:0] ptr_inc;
    logic [ADDR_W-1:0] mem_addr;
    logic [PTR_W-1:0] wp_new;
    logic [CNT_W-1:0] held_new;
    logic [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0] sum_base;
    logic [CNT_W-1:0] held_cur;
    logic             full;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready
                     && (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH);
    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH) begin
            prdata = 32'(wlen_reg);
        end
    end

    always_comb begin
        if (wlen_reg == '0) begin
            win = CNT_W'(1);
        end else if (32'(wlen_reg) > MAX_WINDOW) begin
            win = CNT_W'(MAX_WINDOW);
        end else begin
            win = CNT_W'(wlen_reg);
        end
    end

    assign ch_idx   = item_reg.channel[CH_W-1:0];
    assign ch_ok    = 32'(item_reg.channel) < CHANNELS;
    assign held_cur = held_reg[ch_idx];
    assign ptr_eff  = (CNT_W'(wp_reg[ch_idx]) >= win) ? '0 : wp_reg[ch_idx];
    assign ptr_inc  = CNT_W'(ptr_eff) + 1'b1;
    assign wp_new   = (ptr_inc >= win) ? '0 : ptr_inc[PTR_W-1:0];
    assign mem_addr = {ch_idx, ptr_eff};
    assign full     = held_cur >= win;
    assign held_new = full ? win : held_cur + 1'b1;
    assign sum_base = full ? sum_reg[ch_idx] - SUM_W'(rd_data_reg) : sum_reg[ch_idx];
    assign sum_new  = sum_base + SUM_W'(item_reg.sample[SAMPLE_BITS-1:0]);

    always_comb begin
        state_next     = state_reg;
        res_avg_next   = res_avg_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        clear_all      = 1'b0;
        ch_wr          = 1'b0;
        mem_we         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg[ch_idx];
        div_req.divisor  = held_cur;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                case (item_reg.action)
                    ACT_CLEAR_ALL: clear_all = 1'b1;
                    ACT_PUSH: begin
                        ch_wr  = ch_ok;
                        mem_we = ch_ok;
                    end
                    ACT_CLEAR_CH: ch_wr = ch_ok;
                    default: ;
                endcase
                state_next = S_EVAL;
            end
            S_EVAL: begin
                res_avg_next = '0;
                res_cnt_next = ch_ok ? 7'(held_cur) : '0;
                if (ch_ok && held_cur != '0) begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    res_avg_next = 12'(div_rsp.quotient);
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wlen_reg      <= WINDOW_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                wlen_reg <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we || clear_all) begin
            for (int i = 0; i < CHANNELS; i++) begin
                wp_reg[i]   <= '0;
                held_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end else if (ch_wr) begin
            if (item_reg.action == ACT_PUSH) begin
                wp_reg[ch_idx]   <= wp_new;
                held_reg[ch_idx] <= held_new;
                sum_reg[ch_idx]  <= sum_new;
            end else begin
                wp_reg[ch_idx]   <= '0;
                held_reg[ch_idx] <= '0;
                sum_reg[ch_idx]  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        res_avg_reg <= res_avg_next;
        res_cnt_reg <= res_cnt_next;
        if (state_reg == S_DONE && out_valid_next && !(out_valid_reg && !m_ready)) begin
            out_data_reg.average      <= res_avg_reg;
            out_data_reg.sample_count <= res_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sample_mem[mem_addr] <= item_reg.sample[SAMPLE_BITS-1:0];
        end
        rd_data_reg <= sample_mem[mem_addr];
    end

    mma_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while sequencer busy");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.sample_count) <= MAX_WINDOW)
        else $error("sample count above window");

    a_empty_zero_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sample_count == '0) |-> m_data.average == '0)
        else $error("empty channel with nonzero average");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide step");

endmodule
